// ----- src/slr_pkg.sv -----
// shared types and constants for the stereo linear resampler
package slr_pkg;

  // field and register widths
  localparam int SMP_W   = 8;
  localparam int OUT_W   = 16;
  localparam int ENG_W   = 16;
  localparam int DEV_W   = 18;
  localparam int MAXF_W  = 13;
  localparam int PHASE_W = 18;
  localparam int FE_W    = 13;
  localparam int PROD_W  = SMP_W + PHASE_W;
  localparam int QUO_W   = 16;
  localparam int CIDX_W  = 2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_ENGINE_RATE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DEVICE_RATE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MAX_FRAMES  = 2'd2;

  // register reset values and limits
  localparam logic [ENG_W-1:0]  ENG_RESET  = 16'd13379;
  localparam logic [DEV_W-1:0]  DEV_RESET  = 18'd48000;
  localparam logic [MAXF_W-1:0] MAXF_RESET = 13'd4096;
  localparam logic [DEV_W-1:0]  DEV_MAX    = 18'd192000;

  // input beat
  typedef struct packed {
    logic signed [SMP_W-1:0] right_sample;
    logic signed [SMP_W-1:0] left_sample;
    logic                    frame_end;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] right_out;
    logic signed [OUT_W-1:0] left_out;
    logic                    run_last;
  } out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_start;
    logic push;
    logic push_last;
    logic capture;
    logic end_ivl;
    logic next_sec;
    logic fin;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic have_held;
    logic last;
    logic sec;
    logic emit_ok;
    logic out_free;
    logic pend_valid;
    logic div_busy;
  } stat_t;

endpackage

// ----- src/stereo_linear_resampler.sv -----
// top level: configuration registers, controller and datapath
// Converts signed 8-bit stereo input beats into 16-bit stereo result beats by
// linear interpolation between successive samples of a frame; frame_end marks
// the last sample of a frame, which is held across its interval, and run_last
// flags the final result caused by each input beat. One input beat is worked
// on at a time, and the next beat is taken only after all results caused by
// the current one (0 to 32) are worked out, later still while out_stall holds a
// result back; that work is set mostly by the 16-step serial divider that
// both channels run in parallel for every result. A result may still wait in
// the output register while the next input beat is taken. Configuration writes
// are always ready; a write that would leave device_rate above 16 times
// engine_rate, device_rate zero or above 192000, engine_rate zero or
// max_frames zero is dropped, as is a write to an unknown index.
module stereo_linear_resampler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  slr_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output slr_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [slr_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import slr_pkg::*;

  logic [ENG_W-1:0]  eng_r, eng_nxt;
  logic [DEV_W-1:0]  dev_r, dev_nxt;
  logic [MAXF_W-1:0] maxf_r, maxf_nxt;
  logic [ENG_W-1:0]  wr_eng;
  logic [DEV_W-1:0]  wr_dev;
  logic [MAXF_W-1:0] wr_maxf;
  cmd_t              cmd;
  stat_t             stat;

  assign cfg_ready = 1'b1;
  assign wr_eng    = cfg_data[ENG_W-1:0];
  assign wr_dev    = cfg_data[DEV_W-1:0];
  assign wr_maxf   = cfg_data[MAXF_W-1:0];

  // register writes with rate ratio check
  always_comb begin
    eng_nxt  = eng_r;
    dev_nxt  = dev_r;
    maxf_nxt = maxf_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENGINE_RATE: begin
          if (wr_eng != '0 && {2'b00, dev_r} <= {wr_eng, 4'b0000}) begin
            eng_nxt = wr_eng;
          end
        end
        REG_DEVICE_RATE: begin
          if (wr_dev != '0 && wr_dev <= DEV_MAX && {2'b00, wr_dev} <= {eng_r, 4'b0000}) begin
            dev_nxt = wr_dev;
          end
        end
        REG_MAX_FRAMES: begin
          if (wr_maxf != '0) begin
            maxf_nxt = wr_maxf;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r  <= ENG_RESET;
      dev_r  <= DEV_RESET;
      maxf_r <= MAXF_RESET;
    end else begin
      eng_r  <= eng_nxt;
      dev_r  <= dev_nxt;
      maxf_r <= maxf_nxt;
    end
  end

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  slr_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .eng_rate   (eng_r),
    .dev_rate   (dev_r),
    .max_frames (maxf_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- src/slr_div.sv -----
// restoring serial divider lane, one quotient bit per cycle
module slr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [slr_pkg::DEV_W-1:0]   dvd_hi,
  input  logic [slr_pkg::SMP_W-1:0]   dvd_lo,
  input  logic [slr_pkg::DEV_W-1:0]   dvs,
  output logic                        busy,
  output logic [slr_pkg::QUO_W-1:0]   quo
);
  import slr_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [DEV_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEV_W:0]   trial;
  logic [DEV_W:0]   diff;

  // one trial subtract per cycle
  assign trial = {rem_r, sh_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = dvd_hi;
      sh_nxt   = {dvd_lo, {(QUO_W-SMP_W){1'b0}}};
      cnt_nxt  = CNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs}) begin
        rem_nxt = diff[DEV_W-1:0];
        sh_nxt  = {sh_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEV_W-1:0];
        sh_nxt  = {sh_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy = busy_r;
  assign quo  = sh_r;

endmodule

// ----- src/slr_dpath.sv -----
// resampler datapath: frame state, phase, products, dividers, result registers
module slr_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slr_pkg::in_t                 in_data,
  input  logic [slr_pkg::ENG_W-1:0]    eng_rate,
  input  logic [slr_pkg::DEV_W-1:0]    dev_rate,
  input  logic [slr_pkg::MAXF_W-1:0]   max_frames,
  input  slr_pkg::cmd_t                cmd,
  output slr_pkg::stat_t               stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output slr_pkg::out_t                out_data
);
  import slr_pkg::*;

  // current beat and interval select
  logic signed [SMP_W-1:0] cur_r_r, cur_l_r;
  logic                    last_r;
  logic                    sec_r, sec_nxt;

  // frame state
  logic signed [SMP_W-1:0] held_r_r, held_r_nxt, held_l_r, held_l_nxt;
  logic                    have_held_r, have_held_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic [FE_W-1:0]         fe_r, fe_nxt;

  // products and signs
  logic [PROD_W-1:0]       prod_r_r, prod_l_r;
  logic                    neg_r_r, neg_l_r;
  logic signed [SMP_W-1:0] s0_r_r, s0_l_r;

  // result registers
  out_t                    pend_r;
  logic                    pend_valid_r, pend_valid_nxt;
  out_t                    out_r;
  logic                    out_valid_r, out_valid_nxt;

  logic signed [SMP_W-1:0] s0_r, s0_l;
  logic signed [SMP_W:0]   dif_r, dif_l;
  logic [SMP_W:0]          mag_r, mag_l;
  logic [QUO_W-1:0]        quo_r, quo_l;
  logic                    busy_r, busy_l;
  logic [QUO_W-1:0]        part_r, part_l;
  logic [OUT_W-1:0]        res_r, res_l;
  logic [PHASE_W:0]        phase_sum;
  logic                    out_free;

  // interval endpoints: blend held toward current, or hold current
  assign s0_r  = sec_r ? cur_r_r : held_r_r;
  assign s0_l  = sec_r ? cur_l_r : held_l_r;
  assign dif_r = {cur_r_r[SMP_W-1], cur_r_r} - {s0_r[SMP_W-1], s0_r};
  assign dif_l = {cur_l_r[SMP_W-1], cur_l_r} - {s0_l[SMP_W-1], s0_l};
  assign mag_r = dif_r[SMP_W] ? (SMP_W+1)'(-dif_r) : dif_r;
  assign mag_l = dif_l[SMP_W] ? (SMP_W+1)'(-dif_l) : dif_l;

  // magnitude times phase, registered ahead of the dividers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r_r <= PROD_W'(mag_r[SMP_W-1:0]) * PROD_W'(phase_r);
      prod_l_r <= PROD_W'(mag_l[SMP_W-1:0]) * PROD_W'(phase_r);
      neg_r_r  <= dif_r[SMP_W];
      neg_l_r  <= dif_l[SMP_W];
      s0_r_r   <= s0_r;
      s0_l_r   <= s0_l;
    end
  end

  // dividend is product << 8, quotient bounded below 2^16
  slr_div u_div_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .dvd_hi (prod_r_r[PROD_W-1:SMP_W]),
    .dvd_lo (prod_r_r[SMP_W-1:0]),
    .dvs    (dev_rate),
    .busy   (busy_r),
    .quo    (quo_r)
  );

  slr_div u_div_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .dvd_hi (prod_l_r[PROD_W-1:SMP_W]),
    .dvd_lo (prod_l_r[SMP_W-1:0]),
    .dvs    (dev_rate),
    .busy   (busy_l),
    .quo    (quo_l)
  );

  // apply sign and add base sample in 16-bit scale
  assign part_r = neg_r_r ? QUO_W'(-quo_r) : quo_r;
  assign part_l = neg_l_r ? QUO_W'(-quo_l) : quo_l;
  assign res_r  = {s0_r_r, {(OUT_W-SMP_W){1'b0}}} + part_r;
  assign res_l  = {s0_l_r, {(OUT_W-SMP_W){1'b0}}} + part_l;

  assign phase_sum = {1'b0, phase_r} + {{(PHASE_W+1-ENG_W){1'b0}}, eng_rate};

  // frame state and phase updates
  always_comb begin
    sec_nxt       = sec_r;
    held_r_nxt    = held_r_r;
    held_l_nxt    = held_l_r;
    have_held_nxt = have_held_r;
    phase_nxt     = phase_r;
    fe_nxt        = fe_r;
    if (cmd.load_in) begin
      sec_nxt = !have_held_r;
    end
    if (cmd.next_sec) begin
      sec_nxt = 1'b1;
    end
    if (cmd.capture) begin
      phase_nxt = phase_sum[PHASE_W-1:0];
      fe_nxt    = fe_r + 1'b1;
    end
    if (cmd.end_ivl) begin
      phase_nxt = (phase_r >= dev_rate) ? phase_r - dev_rate : '0;
    end
    if (cmd.fin) begin
      if (last_r) begin
        fe_nxt        = '0;
        have_held_nxt = 1'b0;
        held_r_nxt    = '0;
        held_l_nxt    = '0;
      end else begin
        have_held_nxt = 1'b1;
        held_r_nxt    = cur_r_r;
        held_l_nxt    = cur_l_r;
      end
    end
  end

  // result staging: pending result waits until its run_last is known
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.push) begin
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.capture) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r        <= 1'b0;
      held_r_r     <= '0;
      held_l_r     <= '0;
      have_held_r  <= 1'b0;
      phase_r      <= '0;
      fe_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      sec_r        <= sec_nxt;
      held_r_r     <= held_r_nxt;
      held_l_r     <= held_l_nxt;
      have_held_r  <= have_held_nxt;
      phase_r      <= phase_nxt;
      fe_r         <= fe_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_r_r <= in_data.right_sample;
      cur_l_r <= in_data.left_sample;
      last_r  <= in_data.frame_end;
    end
    if (cmd.capture) begin
      pend_r.right_out <= res_r;
      pend_r.left_out  <= res_l;
      pend_r.run_last  <= 1'b0;
    end
    if (cmd.push) begin
      out_r.right_out <= pend_r.right_out;
      out_r.left_out  <= pend_r.left_out;
      out_r.run_last  <= cmd.push_last;
    end
  end

  // status back to the controller
  always_comb begin
    stat.have_held  = have_held_r;
    stat.last       = last_r;
    stat.sec        = sec_r;
    stat.emit_ok    = (phase_r < dev_rate) && (fe_r < max_frames);
    stat.out_free   = out_free;
    stat.pend_valid = pend_valid_r;
    stat.div_busy   = busy_r || busy_l;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/slr_ctrl.sv -----
// resampler controller: walks intervals and outputs for one input beat
module slr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output slr_pkg::cmd_t  cmd,
  input  slr_pkg::stat_t stat
);
  import slr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_MULT  = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_PUSH  = 9'b001000000,
    S_ENDI  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        state_nxt = (stat.have_held || stat.last) ? S_CHECK : S_FLUSH;
      end
      S_CHECK: begin
        state_nxt = stat.emit_ok ? S_MULT : S_ENDI;
      end
      S_MULT: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_PUSH;
        end
      end
      // previous result goes out as not last, new one becomes pending
      S_PUSH: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.push    = stat.pend_valid;
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_ENDI: begin
        cmd.end_ivl = 1'b1;
        if (!stat.sec && stat.last) begin
          cmd.next_sec = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      // final pending result carries run_last
      S_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.push      = stat.pend_valid;
          cmd.push_last = 1'b1;
          cmd.fin       = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_stereo_linear_resampler.sv -----
// testbench for the stereo linear resampler: random traffic checked against a local predictor
module tb_stereo_linear_resampler;
  import slr_pkg::*;

  localparam int unsigned RATIO_MAX  = 16;
  localparam int          SCALE      = 256;
  localparam int          HOLDOFF    = 100;
  localparam int          FINAL_WAIT = 700;
  localparam int          QUIET_MAX  = 3000;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [31:0]         cfg_data  = '0;

  // predictor registers and state
  logic [ENG_W-1:0]    eng_q     = ENG_RESET;
  logic [DEV_W-1:0]    dev_q     = DEV_RESET;
  logic [MAXF_W-1:0]   maxf_q    = MAXF_RESET;
  logic signed [SMP_W-1:0] held_r_q = '0;
  logic signed [SMP_W-1:0] held_l_q = '0;
  logic                holding_q = 1'b0;
  logic [PHASE_W-1:0]  phase_q   = '0;
  logic [FE_W-1:0]     emitted_q = '0;

  in_t  pending_in[$];
  out_t expected_out[$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  int   gap_left    = 0;
  int   frame_left  = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int   mode_left   = 0;
  int   stall_run   = 0;
  logic stall_on    = 1'b0;

  stereo_linear_resampler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // s0<<8 plus the scaled delta, division truncating toward zero
  function automatic logic [OUT_W-1:0] lerp16(input int s0, input int s1,
                                               input logic [PHASE_W-1:0] frac);
    longint delta;
    longint part;
    delta = longint'(s1 - s0) * SCALE;
    part  = (delta * longint'(frac)) / longint'(dev_q);
    return OUT_W'(s0 * SCALE + int'(part));
  endfunction

  // outputs of one sample interval, then phase steps past it
  function automatic int sweep_interval(input int r0, input int r1,
                                        input int l0, input int l1);
    int   n;
    out_t b;
    n = 0;
    while (phase_q < dev_q && emitted_q < maxf_q) begin
      b.right_out = lerp16(r0, r1, phase_q);
      b.left_out  = lerp16(l0, l1, phase_q);
      b.run_last  = 1'b0;
      expected_out.push_back(b);
      n++;
      emitted_q++;
      phase_q = phase_q + eng_q;
    end
    if (phase_q >= dev_q) phase_q = phase_q - dev_q;
    else phase_q = '0;
    return n;
  endfunction

  // expected results caused by one accepted input beat
  function automatic void resample_beat(input in_t x);
    int   r;
    int   l;
    int   n;
    out_t b;
    r = x.right_sample;
    l = x.left_sample;
    n = 0;
    if (holding_q) n += sweep_interval(held_r_q, r, held_l_q, l);
    if (x.frame_end) begin
      n += sweep_interval(r, r, l, l);
      emitted_q = '0;
      holding_q = 1'b0;
      held_r_q  = '0;
      held_l_q  = '0;
    end else begin
      held_r_q  = x.right_sample;
      held_l_q  = x.left_sample;
      holding_q = 1'b1;
    end
    if (n > 0) begin
      b = expected_out.pop_back();
      b.run_last = 1'b1;
      expected_out.push_back(b);
    end
  endfunction

  // register write as the block applies it, rejected values dropped
  function automatic void apply_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] value);
    int unsigned v;
    case (idx)
      REG_ENGINE_RATE: begin
        v = 32'(value[ENG_W-1:0]);
        if (v != 0 && int'(dev_q) <= RATIO_MAX * v) eng_q = ENG_W'(v);
      end
      REG_DEVICE_RATE: begin
        v = 32'(value[DEV_W-1:0]);
        if (v != 0 && v <= DEV_MAX && v <= RATIO_MAX * eng_q) dev_q = DEV_W'(v);
      end
      REG_MAX_FRAMES: begin
        v = 32'(value[MAXF_W-1:0]);
        if (v != 0) maxf_q = MAXF_W'(v);
      end
      default: ;
    endcase
  endfunction

  function automatic in_t mk_in(input int r, input int l, input logic fe);
    in_t x;
    x.right_sample = SMP_W'(r);
    x.left_sample  = SMP_W'(l);
    x.frame_end    = fe;
    return x;
  endfunction

  // extremes now and then, otherwise any value
  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return -128;
      1: return 127;
      2: return 0;
      3: return -1;
      default: return int'($signed(SMP_W'($urandom_range(0, 255))));
    endcase
  endfunction

  // frames of random length, single-sample frames among them
  task automatic queue_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (frame_left == 0)
        frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      pending_in.push_back(mk_in(rand_sample(), rand_sample(), frame_left == 1));
      frame_left--;
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus waits until every queued beat is sent and every expected result is in
  task automatic wait_drained();
    while (pending_in.size() != 0 || in_valid || expected_out.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (HOLDOFF) @(posedge clk);
  endtask

  // input driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) resample_beat(in_data);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_in.size() > 0) begin
          in_data  <= pending_in.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall pattern
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_out.size() == 0) begin
        report_error($sformatf("unexpected result beat right=%0d left=%0d last=%0b",
                               out_data.right_out, out_data.left_out, out_data.run_last));
      end else begin
        want = expected_out.pop_front();
        if (out_data.right_out !== want.right_out)
          report_error($sformatf("right_out got %0d expected %0d",
                                 out_data.right_out, want.right_out));
        if (out_data.left_out !== want.left_out)
          report_error($sformatf("left_out got %0d expected %0d",
                                 out_data.left_out, want.left_out));
        if (out_data.run_last !== want.run_last)
          report_error($sformatf("run_last got %0b expected %0b",
                                 out_data.run_last, want.run_last));
      end
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 30);
          stall_on  = ~stall_on;
        end
        stall_run--;
        out_stall <= stall_on;
      end
    endcase
  end

  // watchdog on cycles with no beat moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= QUIET_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset rates: extremes, single-sample frame, longer frames
    pending_in.push_back(mk_in(127, -128, 1'b1));
    pending_in.push_back(mk_in(-128, 127, 1'b0));
    pending_in.push_back(mk_in(127, -128, 1'b0));
    pending_in.push_back(mk_in(0, 0, 1'b0));
    pending_in.push_back(mk_in(-1, 1, 1'b1));
    pending_in.push_back(mk_in(100, -100, 1'b0));
    pending_in.push_back(mk_in(-100, 100, 1'b0));
    pending_in.push_back(mk_in(1, -1, 1'b0));
    pending_in.push_back(mk_in(-128, -128, 1'b0));
    pending_in.push_back(mk_in(127, 127, 1'b1));
    settle();

    // cap of one output per frame, hit mid-frame
    write_reg(REG_MAX_FRAMES, 32'd1);
    pending_in.push_back(mk_in(10, 20, 1'b0));
    pending_in.push_back(mk_in(30, -40, 1'b0));
    pending_in.push_back(mk_in(50, 60, 1'b0));
    settle();

    // cap raised mid-frame, output resumes
    write_reg(REG_MAX_FRAMES, 32'd4096);
    pending_in.push_back(mk_in(-5, 7, 1'b0));
    pending_in.push_back(mk_in(1, 2, 1'b1));
    settle();

    // large carry: step far above the interval
    write_reg(REG_ENGINE_RATE, 32'd65535);
    write_reg(REG_DEVICE_RATE, 32'd4096);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    pending_in.push_back(mk_in(20, -20, 1'b0));
    pending_in.push_back(mk_in(40, -40, 1'b0));
    pending_in.push_back(mk_in(60, -60, 1'b0));
    pending_in.push_back(mk_in(-128, 127, 1'b1));
    settle();

    // rejected writes, then the full 16x ratio on a two-beat frame
    write_reg(REG_DEVICE_RATE, 32'd0);
    write_reg(REG_DEVICE_RATE, 32'd192001);
    write_reg(REG_ENGINE_RATE, 32'd0);
    write_reg(REG_MAX_FRAMES, 32'd0);
    write_reg(REG_ENGINE_RATE, 32'd1);
    write_reg(REG_DEVICE_RATE, 32'hFFFC_0010);
    write_reg(REG_ENGINE_RATE, 32'hABCD_0001);
    write_reg(REG_DEVICE_RATE, 32'd17);
    pending_in.push_back(mk_in(127, -128, 1'b0));
    pending_in.push_back(mk_in(-128, 127, 1'b1));
    settle();

    // highest device rate at the full ratio
    write_reg(REG_ENGINE_RATE, 32'd12000);
    write_reg(REG_DEVICE_RATE, 32'd192000);
    write_reg(REG_MAX_FRAMES, 32'd4096);
    queue_random(25);
    settle();

    // fastest engine rate with a small cap
    write_reg(REG_ENGINE_RATE, 32'd65535);
    write_reg(REG_MAX_FRAMES, 32'hFFFF_E003);
    queue_random(60);
    settle();

    // lowest device rate: outputs rare, carry drains slowly
    write_reg(REG_DEVICE_RATE, 32'd1);
    write_reg(REG_MAX_FRAMES, 32'd4096);
    queue_random(30);
    settle();

    // random rates and caps
    for (int k = 0; k < 3; k++) begin
      int unsigned eng;
      int unsigned dev_top;
      eng     = $urandom_range(600, 65535);
      dev_top = (RATIO_MAX * eng > DEV_MAX) ? DEV_MAX : RATIO_MAX * eng;
      write_reg(REG_DEVICE_RATE, 32'd1);
      write_reg(REG_ENGINE_RATE, eng);
      write_reg(REG_DEVICE_RATE, $urandom_range(1, dev_top));
      write_reg(REG_MAX_FRAMES, $urandom_range(1, 40));
      queue_random(40);
      settle();
    end

    // lowest rates, one output per interval
    write_reg(REG_DEVICE_RATE, 32'd1);
    write_reg(REG_ENGINE_RATE, 32'd1);
    write_reg(REG_MAX_FRAMES, 32'd4096);
    queue_random(40);
    settle();

    // back to the reset rates
    write_reg(REG_ENGINE_RATE, 32'd13379);
    write_reg(REG_DEVICE_RATE, 32'd48000);
    queue_random(40);

    wait_drained();
    repeat (FINAL_WAIT) @(posedge clk);
    if (expected_out.size() != 0)
      report_error($sformatf("%0d expected results never came", expected_out.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
